// ----- rtl/dntp_pkg.sv -----
// Package for the decimal number text parser: payload structs, token
// classes, parse phases and field widths. No dependencies.
package dntp_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 8;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_string;
	} dntp_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_W-1:0]        fraction_digits;
	} dntp_out_t;

	typedef enum logic [2:0] {
		TK_SPACE = 3'd0,
		TK_MINUS = 3'd1,
		TK_PLUS  = 3'd2,
		TK_DIGIT = 3'd3,
		TK_POINT = 3'd4,
		TK_OTHER = 3'd5
	} dntp_kind_t;

	typedef struct packed {
		dntp_kind_t kind;
		logic [3:0] digit;
		logic       last;
	} dntp_token_t;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_STOP   = 3'b100
	} dntp_phase_t;

endpackage

// ----- rtl/dntp_front.sv -----
// Front end: accepts characters, classifies them into tokens and holds
// one token in a stage register. Depends on dntp_pkg.
module dntp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 allow_fraction,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dntp_pkg::dntp_in_t   in_data,
	output logic                 tok_valid,
	input  logic                 tok_ready,
	output dntp_pkg::dntp_token_t tok
);
	import dntp_pkg::*;

	logic        valid_s1;
	dntp_token_t tok_s1;
	dntp_token_t tok_c;
	logic        advance;

	always_comb begin
		tok_c.last  = in_data.end_of_string;
		tok_c.digit = 4'(in_data.ch - CH_ZERO);
		if (in_data.ch == CH_SPACE || in_data.ch == CH_TAB) begin
			tok_c.kind = TK_SPACE;
		end else if (in_data.ch == CH_MINUS) begin
			tok_c.kind = TK_MINUS;
		end else if (in_data.ch == CH_PLUS) begin
			tok_c.kind = TK_PLUS;
		end else if (in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE) begin
			tok_c.kind = TK_DIGIT;
		end else if (in_data.ch == CH_POINT && allow_fraction) begin
			tok_c.kind = TK_POINT;
		end else begin
			tok_c.kind = TK_OTHER;
		end
	end

	assign advance  = !valid_s1 || tok_ready;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			tok_s1 <= tok_c;
		end
	end

	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

endmodule

// ----- rtl/dntp_queue.sv -----
// Short FIFO of tokens between front and back end.
// Generic over width; no package dependency.
module dntp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/dntp_back.sv -----
// Back end: parse state machine, signed accumulator, fraction counter and
// the result register. Depends on dntp_pkg.
module dntp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_valid,
	output logic                  tok_pop,
	input  dntp_pkg::dntp_token_t tok,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dntp_pkg::dntp_out_t   out_data
);
	import dntp_pkg::*;

	dntp_phase_t        phase_q, phase_d;
	logic               neg_q, neg_d;
	logic               point_q, point_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               out_valid_q;
	dntp_out_t          out_q;
	logic [VALUE_W-1:0] acc_x10;
	logic [VALUE_W-1:0] digit_ext;
	logic               do_collect;

	// The accumulator carries the sign already: a negative number is built
	// as acc*10 - d, so no negate is needed at the end.
	assign acc_x10   = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0};
	assign digit_ext = VALUE_W'(tok.digit);

	assign tok_pop = tok_valid && (!tok.last || !out_valid_q || !out_stall);

	always_comb begin
		phase_d    = phase_q;
		neg_d      = neg_q;
		point_d    = point_q;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		do_collect = 1'b0;
		unique case (phase_q)
			PH_SKIP: begin
				unique case (tok.kind)
					TK_SPACE: ;
					TK_MINUS: begin
						neg_d   = 1'b1;
						phase_d = PH_DIGITS;
					end
					TK_PLUS: phase_d = PH_DIGITS;
					default: do_collect = 1'b1;
				endcase
			end
			PH_DIGITS: do_collect = 1'b1;
			PH_STOP: ;
			default: phase_d = PH_STOP;
		endcase
		if (do_collect) begin
			unique case (tok.kind)
				TK_DIGIT: begin
					if (point_q && cnt_q != '1) begin
						cnt_d = cnt_q + 1'b1;
					end
					acc_d   = neg_q ? acc_x10 - digit_ext : acc_x10 + digit_ext;
					phase_d = PH_DIGITS;
				end
				TK_POINT: begin
					point_d = 1'b1;
					phase_d = PH_DIGITS;
				end
				default: phase_d = PH_STOP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			neg_q       <= 1'b0;
			point_q     <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop) begin
				if (tok.last) begin
					phase_q <= PH_SKIP;
					neg_q   <= 1'b0;
					point_q <= 1'b0;
					acc_q   <= '0;
					cnt_q   <= '0;
				end else begin
					phase_q <= phase_d;
					neg_q   <= neg_d;
					point_q <= point_d;
					acc_q   <= acc_d;
					cnt_q   <= cnt_d;
				end
			end
			if (tok_pop && tok.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && tok.last) begin
			out_q.value           <= acc_d;
			out_q.fraction_digits <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/decimal_number_text_parser_core.sv -----
// Top level of the decimal number text parser: front end, token queue,
// back end and the allow_fraction register. Depends on dntp_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_stall  | in_data: ch[7:0], end_of_string
//  out      | out_valid / out_stall| out_data: value[31:0] s, fraction_digits[7:0]
//  cfg      | cfg_we               | cfg_wdata: allow_fraction
//
// One character per cycle sustained while in_stall stays low; a result passes
// from its end-of-string character through the front stage, then the queue,
// then the result register.
// The back end's multiply-by-ten and add sets the cycle time.
// Reset clears the parse state and sets allow_fraction to 1.
// out_stall only holds back end-of-string transactions; other characters
// keep draining, and in_stall rises only when the front stage and queue fill.
module decimal_number_text_parser_core #(
	parameter int QUEUE_DEPTH = dntp_pkg::Q_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dntp_pkg::dntp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dntp_pkg::dntp_out_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import dntp_pkg::*;

	localparam int TOK_W = $bits(dntp_token_t);

	logic        allow_fraction_q;
	logic        f_valid;
	logic        f_ready;
	dntp_token_t f_tok;
	logic        q_valid;
	logic        q_pop;
	dntp_token_t q_head;
	logic [TOK_W-1:0] q_head_bits;

	// Front end samples it on each '.'; user writes only while idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_fraction_q <= 1'b1;
		end else if (cfg_we) begin
			allow_fraction_q <= cfg_wdata;
		end
	end

	dntp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.allow_fraction (allow_fraction_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.tok_valid      (f_valid),
		.tok_ready      (f_ready),
		.tok            (f_tok)
	);

	// Decouples the front from the back so a stalled result does not
	// immediately back up the character stream.
	dntp_queue #(
		.WIDTH (TOK_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_tok),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_head_bits)
	);

	assign q_head = dntp_token_t'(q_head_bits);

	dntp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_pop   (q_pop),
		.tok       (q_head),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// The back end never pops an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("token popped from empty queue");

	// A fresh result always comes from an end-of-string token.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop && q_head.last))
		else $error("result without end-of-string token");

	// A taken result is not shown again unless a new one was loaded.
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(q_pop && q_head.last) |=> !out_valid)
		else $error("result repeated");

endmodule
